[hdl/nnis_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnis_pkg
// Shared types and constants of the nearest-neighbor image scaler.
// ----------------------------------------------------------------------------
package nnis_pkg;

  localparam int MAX_SRC_DIM_DEF = 64;
  localparam int MAX_DST_DIM_DEF = 1024;
  localparam int PIXEL_BITS_DEF  = 32;

  localparam int COORD_W    = 10;
  localparam int COLOR_W    = 32;
  localparam int SRC_REG_W  = 7;
  localparam int DST_REG_W  = 11;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int IN_TDATA_W = 56;

  localparam logic [SRC_REG_W-1:0] SRC_SIZE_RST = 7'd32;
  localparam logic [DST_REG_W-1:0] DST_SIZE_RST = 11'd8;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef enum logic [1:0] {
    REG_SRC_WIDTH,
    REG_SRC_HEIGHT,
    REG_DST_WIDTH,
    REG_DST_HEIGHT
  } nnis_reg_t;

  // control that travels with every item down the pipeline
  typedef struct packed {
    logic valid;
    logic rd;
    logic ok;
  } nnis_ctl_t;

endpackage

[hdl/nearest_neighbor_image_scaler.sv]
`timescale 1ns / 1ps
// Path: input register, scale stage, divider stages, address stage, store, output register.
// One item per cycle while the skid is empty; divider stages and one-port store are pipelined.
// Writes give no result; a read right behind a write to the same entry sees the new colour.
// Reset clears all valid bits and loads the size registers (32x32 source, 8x8 destination).
// The pixel store is not cleared; an entry holds no defined colour until written.
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler
// Stream-in, stream-out nearest-neighbor scaler over a stored source image.
// ----------------------------------------------------------------------------
module nearest_neighbor_image_scaler #(
  parameter int MAX_SRC_DIM = nnis_pkg::MAX_SRC_DIM_DEF,
  parameter int MAX_DST_DIM = nnis_pkg::MAX_DST_DIM_DEF,
  parameter int PIXEL_BITS  = nnis_pkg::PIXEL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [nnis_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [nnis_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [nnis_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [9:0] pos_x, [19:10] pos_y, [51:20] write_color, [55:52] zero
  input  logic [nnis_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [0] kind
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [31:0] pixel_color
  output logic [nnis_pkg::COLOR_W-1:0]        m_axis_tdata,
  // [0] bad_coord
  output logic                                m_axis_tuser
);

  localparam int COORD_W = nnis_pkg::COORD_W;
  localparam int COLOR_W = nnis_pkg::COLOR_W;
  localparam int SW_W    = $clog2(MAX_SRC_DIM + 1);
  localparam int DVW     = $clog2(MAX_DST_DIM + 1);
  localparam int QB      = $clog2(MAX_SRC_DIM);
  localparam int NDS     = (QB + 1) / 2;
  localparam int PW      = COORD_W + SW_W;
  localparam int SIDE_W  = COLOR_W + 2 * COORD_W;
  localparam int DEPTH   = MAX_SRC_DIM * MAX_SRC_DIM;
  localparam int AW      = $clog2(MAX_SRC_DIM * MAX_SRC_DIM);

  logic [SW_W-1:0] sw;
  logic [SW_W-1:0] sh;
  logic [DVW-1:0]  dw;
  logic [DVW-1:0]  dh;
  logic            adv;

  assign pready = 1'b1;

  nnis_cfg #(
    .MAX_SRC_DIM (MAX_SRC_DIM),
    .MAX_DST_DIM (MAX_DST_DIM),
    .SW_W        (SW_W),
    .DVW         (DVW)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .sw      (sw),
    .sh      (sh),
    .dw      (dw),
    .dh      (dh)
  );

  // input register
  logic               s0_valid;
  logic               s0_kind;
  logic [COORD_W-1:0] s0_x;
  logic [COORD_W-1:0] s0_y;
  logic [COLOR_W-1:0] s0_color;

  assign s_axis_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_kind  <= s_axis_tuser;
      s0_x     <= s_axis_tdata[COORD_W-1:0];
      s0_y     <= s_axis_tdata[2*COORD_W-1:COORD_W];
      s0_color <= s_axis_tdata[2*COORD_W+COLOR_W-1:2*COORD_W];
    end
  end

  // scale stage: numerators and range checks
  nnis_pkg::nnis_ctl_t s1_ctl_next;

  always_comb begin
    s1_ctl_next.valid = s0_valid;
    s1_ctl_next.rd    = (s0_kind == nnis_pkg::KIND_READ);
    if (s0_kind == nnis_pkg::KIND_READ) begin
      s1_ctl_next.ok = (32'(s0_x) < 32'(dw)) && (32'(s0_y) < 32'(dh));
    end else begin
      s1_ctl_next.ok = (32'(s0_x) < 32'(sw)) && (32'(s0_y) < 32'(sh));
    end
  end

  nnis_pkg::nnis_ctl_t dv_ctl  [NDS+1];
  logic [PW-1:0]       dv_rx   [NDS+1];
  logic [PW-1:0]       dv_ry   [NDS+1];
  logic [QB-1:0]       dv_qx   [NDS+1];
  logic [QB-1:0]       dv_qy   [NDS+1];
  logic [SIDE_W-1:0]   dv_side [NDS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_ctl[0] <= '0;
    end else if (adv) begin
      dv_ctl[0] <= s1_ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rx[0]   <= PW'(s0_x) * PW'(sw);
      dv_ry[0]   <= PW'(s0_y) * PW'(sh);
      dv_qx[0]   <= '0;
      dv_qy[0]   <= '0;
      dv_side[0] <= {s0_color, s0_y, s0_x};
    end
  end

  for (genvar k = 0; k < NDS; k++) begin : g_div
    nnis_div_stage #(
      .QB     (QB),
      .PW     (PW),
      .DVW    (DVW),
      .SIDE_W (SIDE_W),
      .TOP    (QB - 1 - 2 * k)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .ctl_in    (dv_ctl[k]),
      .rem_x_in  (dv_rx[k]),
      .rem_y_in  (dv_ry[k]),
      .q_x_in    (dv_qx[k]),
      .q_y_in    (dv_qy[k]),
      .side_in   (dv_side[k]),
      .dw        (dw),
      .dh        (dh),
      .ctl_out   (dv_ctl[k+1]),
      .rem_x_out (dv_rx[k+1]),
      .rem_y_out (dv_ry[k+1]),
      .q_x_out   (dv_qx[k+1]),
      .q_y_out   (dv_qy[k+1]),
      .side_out  (dv_side[k+1])
    );
  end

  // address stage
  nnis_pkg::nnis_ctl_t sa_ctl;
  logic [AW-1:0]       sa_addr;
  logic [COLOR_W-1:0]  sa_color;
  logic [AW-1:0]       addr_next;
  logic [COORD_W-1:0]  side_x;
  logic [COORD_W-1:0]  side_y;

  assign side_x = dv_side[NDS][COORD_W-1:0];
  assign side_y = dv_side[NDS][2*COORD_W-1:COORD_W];

  always_comb begin
    if (dv_ctl[NDS].rd) begin
      addr_next = AW'(AW'(dv_qy[NDS]) * AW'(MAX_SRC_DIM)) + AW'(dv_qx[NDS]);
    end else begin
      addr_next = AW'(AW'(side_y) * AW'(MAX_SRC_DIM)) + AW'(side_x);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_ctl <= '0;
    end else if (adv) begin
      sa_ctl <= dv_ctl[NDS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa_addr  <= addr_next;
      sa_color <= dv_side[NDS][SIDE_W-1:2*COORD_W];
    end
  end

  logic               st_valid;
  logic [COLOR_W-1:0] st_color;
  logic               st_bad;

  nnis_store #(
    .DEPTH      (DEPTH),
    .AW         (AW),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .ctl_in    (sa_ctl),
    .addr      (sa_addr),
    .color_in  (sa_color),
    .out_valid (st_valid),
    .out_color (st_color),
    .out_bad   (st_bad)
  );

  // output register with skid entry; the pipeline runs while the skid is empty
  logic               skid_full;
  logic [COLOR_W-1:0] skid_color;
  logic               skid_bad;
  logic               prod;

  assign adv  = !skid_full;
  assign prod = adv && st_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_full     <= 1'b0;
    end else if (skid_full) begin
      if (m_axis_tready) begin
        skid_full <= 1'b0;
      end
    end else if (prod) begin
      if (!m_axis_tvalid || m_axis_tready) begin
        m_axis_tvalid <= 1'b1;
      end else begin
        skid_full <= 1'b1;
      end
    end else if (m_axis_tvalid && m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (m_axis_tready) begin
        m_axis_tdata <= skid_color;
        m_axis_tuser <= skid_bad;
      end
    end else if (prod) begin
      if (!m_axis_tvalid || m_axis_tready) begin
        m_axis_tdata <= st_color;
        m_axis_tuser <= st_bad;
      end else begin
        skid_color <= st_color;
        skid_bad   <= st_bad;
      end
    end
  end

endmodule

[hdl/nnis_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnis_cfg
// Size registers on the APB port and their registered effective values.
// ----------------------------------------------------------------------------
module nnis_cfg #(
  parameter int MAX_SRC_DIM = nnis_pkg::MAX_SRC_DIM_DEF,
  parameter int MAX_DST_DIM = nnis_pkg::MAX_DST_DIM_DEF,
  parameter int SW_W        = $clog2(nnis_pkg::MAX_SRC_DIM_DEF + 1),
  parameter int DVW         = $clog2(nnis_pkg::MAX_DST_DIM_DEF + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [nnis_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [nnis_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [nnis_pkg::CFG_DATA_W-1:0]     prdata,
  output logic [SW_W-1:0]                     sw,
  output logic [SW_W-1:0]                     sh,
  output logic [DVW-1:0]                      dw,
  output logic [DVW-1:0]                      dh
);

  logic [nnis_pkg::SRC_REG_W-1:0] src_width;
  logic [nnis_pkg::SRC_REG_W-1:0] src_height;
  logic [nnis_pkg::DST_REG_W-1:0] dst_width;
  logic [nnis_pkg::DST_REG_W-1:0] dst_height;
  nnis_pkg::nnis_reg_t            reg_sel;

  // zero acts as one, oversize saturates at the limit
  function automatic logic [31:0] eff_size(input logic [31:0] v, input int lim);
    logic [31:0] r;
    if (v == 32'd0) begin
      r = 32'd1;
    end else if (v > 32'(lim)) begin
      r = 32'(lim);
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign reg_sel = nnis_pkg::nnis_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= nnis_pkg::SRC_SIZE_RST;
      src_height <= nnis_pkg::SRC_SIZE_RST;
      dst_width  <= nnis_pkg::DST_SIZE_RST;
      dst_height <= nnis_pkg::DST_SIZE_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        nnis_pkg::REG_SRC_WIDTH:  src_width  <= pwdata[nnis_pkg::SRC_REG_W-1:0];
        nnis_pkg::REG_SRC_HEIGHT: src_height <= pwdata[nnis_pkg::SRC_REG_W-1:0];
        nnis_pkg::REG_DST_WIDTH:  dst_width  <= pwdata[nnis_pkg::DST_REG_W-1:0];
        nnis_pkg::REG_DST_HEIGHT: dst_height <= pwdata[nnis_pkg::DST_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      nnis_pkg::REG_SRC_WIDTH:  prdata = nnis_pkg::CFG_DATA_W'(src_width);
      nnis_pkg::REG_SRC_HEIGHT: prdata = nnis_pkg::CFG_DATA_W'(src_height);
      nnis_pkg::REG_DST_WIDTH:  prdata = nnis_pkg::CFG_DATA_W'(dst_width);
      nnis_pkg::REG_DST_HEIGHT: prdata = nnis_pkg::CFG_DATA_W'(dst_height);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    sw <= SW_W'(eff_size(32'(src_width), MAX_SRC_DIM));
    sh <= SW_W'(eff_size(32'(src_height), MAX_SRC_DIM));
    dw <= DVW'(eff_size(32'(dst_width), MAX_DST_DIM));
    dh <= DVW'(eff_size(32'(dst_height), MAX_DST_DIM));
  end

endmodule

[hdl/nnis_div_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnis_div_stage
// One stage of the restoring dividers for x and y, up to two quotient bits.
// ----------------------------------------------------------------------------
module nnis_div_stage #(
  parameter int QB     = 6,
  parameter int PW     = 17,
  parameter int DVW    = 11,
  parameter int SIDE_W = 52,
  parameter int TOP    = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  nnis_pkg::nnis_ctl_t ctl_in,
  input  logic [PW-1:0]       rem_x_in,
  input  logic [PW-1:0]       rem_y_in,
  input  logic [QB-1:0]       q_x_in,
  input  logic [QB-1:0]       q_y_in,
  input  logic [SIDE_W-1:0]   side_in,
  input  logic [DVW-1:0]      dw,
  input  logic [DVW-1:0]      dh,
  output nnis_pkg::nnis_ctl_t ctl_out,
  output logic [PW-1:0]       rem_x_out,
  output logic [PW-1:0]       rem_y_out,
  output logic [QB-1:0]       q_x_out,
  output logic [QB-1:0]       q_y_out,
  output logic [SIDE_W-1:0]   side_out
);

  localparam int NB = (TOP >= 1) ? 2 : 1;
  localparam int EW = PW + DVW;

  logic [PW-1:0] rx_next;
  logic [PW-1:0] ry_next;
  logic [QB-1:0] qx_next;
  logic [QB-1:0] qy_next;

  always_comb begin
    logic [EW-1:0] dx;
    logic [EW-1:0] dy;
    rx_next = rem_x_in;
    ry_next = rem_y_in;
    qx_next = q_x_in;
    qy_next = q_y_in;
    for (int j = 0; j < NB; j++) begin
      dx = EW'(dw) << (TOP - j);
      dy = EW'(dh) << (TOP - j);
      if (EW'(rx_next) >= dx) begin
        rx_next          = rx_next - PW'(dx);
        qx_next[TOP - j] = 1'b1;
      end
      if (EW'(ry_next) >= dy) begin
        ry_next          = ry_next - PW'(dy);
        qy_next[TOP - j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_x_out <= rx_next;
      rem_y_out <= ry_next;
      q_x_out   <= qx_next;
      q_y_out   <= qy_next;
      side_out  <= side_in;
    end
  end

endmodule

[hdl/nnis_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnis_store
// Source pixel memory: writes store a colour, reads fetch one with a
// registered read port.
// ----------------------------------------------------------------------------
module nnis_store #(
  parameter int DEPTH      = 4096,
  parameter int AW         = 12,
  parameter int PIXEL_BITS = nnis_pkg::PIXEL_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  nnis_pkg::nnis_ctl_t             ctl_in,
  input  logic [AW-1:0]                   addr,
  input  logic [nnis_pkg::COLOR_W-1:0]    color_in,
  output logic                            out_valid,
  output logic [nnis_pkg::COLOR_W-1:0]    out_color,
  output logic                            out_bad
);

  logic [PIXEL_BITS-1:0] mem [DEPTH];
  logic [PIXEL_BITS-1:0] rdata;
  nnis_pkg::nnis_ctl_t   ctl;

  always_ff @(posedge clk) begin
    if (en) begin
      if (ctl_in.valid && !ctl_in.rd && ctl_in.ok) begin
        mem[addr] <= color_in[PIXEL_BITS-1:0];
      end
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= ctl_in;
    end
  end

  // writes leave no result; out-of-range reads give zero with the flag
  assign out_valid = ctl.valid && ctl.rd;
  assign out_color = ctl.ok ? nnis_pkg::COLOR_W'(rdata) : '0;
  assign out_bad   = !ctl.ok;

endmodule
